// ===== sv/tssm_pkg.sv =====
package tssm_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        CMD_PUSH_ONE = 2'd0,
        CMD_PUSH_TWO = 2'd1,
        CMD_POP_ONE  = 2'd2,
        CMD_POP_TWO  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic    wr_low;
        logic    wr_high;
        logic    rd_low;
        logic    rd_high;
        logic    load_result;
        status_t result_status;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic low_empty;
        logic high_empty;
    } dp_flags_t;

endpackage

// ===== sv/tssm_ctrl.sv =====
module tssm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          cmd,
    output logic                out_valid,
    input  logic                out_stall,
    input  tssm_pkg::dp_flags_t flags,
    output tssm_pkg::dp_cmd_t   dp_cmd
);
    import tssm_pkg::*;

    state_t state_reg;
    state_t state_next;
    cmd_t   op;

    assign op = cmd_t'(cmd);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next           = state_reg;
        in_stall             = 1'b1;
        out_valid            = 1'b0;
        dp_cmd               = '0;
        dp_cmd.result_status = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    dp_cmd.load_result = 1'b1;
                    state_next         = S_OUT;
                    unique case (op)
                        CMD_PUSH_ONE:
                        begin
                            if (flags.full)
                                dp_cmd.result_status = ST_OVERFLOW;
                            else
                                dp_cmd.wr_low = 1'b1;
                        end
                        CMD_PUSH_TWO:
                        begin
                            if (flags.full)
                                dp_cmd.result_status = ST_OVERFLOW;
                            else
                                dp_cmd.wr_high = 1'b1;
                        end
                        CMD_POP_ONE:
                        begin
                            if (flags.low_empty)
                                dp_cmd.result_status = ST_UNDERFLOW;
                            else
                                dp_cmd.rd_low = 1'b1;
                        end
                        CMD_POP_TWO:
                        begin
                            if (flags.high_empty)
                                dp_cmd.result_status = ST_UNDERFLOW;
                            else
                                dp_cmd.rd_high = 1'b1;
                        end
                        default:
                        begin
                            dp_cmd.result_status = ST_OK;
                        end
                    endcase
                end
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/tssm_datapath.sv =====
module tssm_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  tssm_pkg::dp_cmd_t          dp_cmd,
    input  logic signed [31:0]         push_value,
    output tssm_pkg::dp_flags_t        flags,
    output logic signed [31:0]         pop_data,
    output logic [1:0]                 status
);
    import tssm_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];

    logic [CNT_W-1:0]  low_cnt_reg;
    logic [CNT_W-1:0]  low_cnt_next;
    logic [CNT_W-1:0]  high_cnt_reg;
    logic [CNT_W-1:0]  high_cnt_next;
    logic [CNT_W:0]    used_sum;
    logic [CNT_W-1:0]  low_top;
    logic [CNT_W-1:0]  high_top;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [DATA_W-1:0] rd_data_reg;
    logic              use_mem_reg;
    logic [DATA_W-1:0] fixed_data_reg;
    status_t           status_reg;

    assign used_sum         = {1'b0, low_cnt_reg} + {1'b0, high_cnt_reg};
    assign flags.full       = (used_sum >= (CNT_W + 1)'(DEPTH));
    assign flags.low_empty  = (low_cnt_reg == '0);
    assign flags.high_empty = (high_cnt_reg == '0);

    // top of stack two sits at depth minus its count
    assign low_top  = low_cnt_reg - CNT_W'(1);
    assign high_top = CNT_W'(DEPTH) - high_cnt_reg;

    assign wr_addr = dp_cmd.wr_low ? low_cnt_reg[ADDR_W-1:0]
                                   : (ADDR_W'(DEPTH - 1) - high_cnt_reg[ADDR_W-1:0]);
    assign rd_addr = dp_cmd.rd_low ? low_top[ADDR_W-1:0] : high_top[ADDR_W-1:0];

    always_comb
    begin
        low_cnt_next  = low_cnt_reg;
        high_cnt_next = high_cnt_reg;
        if (dp_cmd.wr_low)
            low_cnt_next = low_cnt_reg + CNT_W'(1);
        if (dp_cmd.rd_low)
            low_cnt_next = low_top;
        if (dp_cmd.wr_high)
            high_cnt_next = high_cnt_reg + CNT_W'(1);
        if (dp_cmd.rd_high)
            high_cnt_next = high_cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_cnt_reg  <= '0;
            high_cnt_reg <= '0;
        end
        else
        begin
            low_cnt_reg  <= low_cnt_next;
            high_cnt_reg <= high_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.wr_low || dp_cmd.wr_high)
            mem[wr_addr] <= push_value;
        if (dp_cmd.rd_low || dp_cmd.rd_high)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.load_result)
        begin
            status_reg     <= dp_cmd.result_status;
            use_mem_reg    <= dp_cmd.rd_low || dp_cmd.rd_high;
            fixed_data_reg <= (dp_cmd.result_status == ST_UNDERFLOW) ? '1 : '0;
        end
    end

    assign pop_data = use_mem_reg ? rd_data_reg : fixed_data_reg;
    assign status   = status_reg;

endmodule

// ===== sv/two_stacks_shared_memory.sv =====
// Two LIFO stacks in one 64-word memory: stack one fills upward from word 0,
// stack two downward from the last word. Each input word is a push to either
// stack (with push_value) or a pop from either stack, and gives exactly one
// result word. A push when both stacks together fill the memory is refused
// with status overflow and pop_data 0; a pop from an empty stack gives status
// underflow and pop_data of all ones. The accept edge does the memory write
// or the registered memory read and updates the count, then the result is
// held until it is taken; the next item is accepted in the cycle after the
// result leaves, so no new item is taken while a result is pending. Memory
// contents need no clearing after reset, since a pop only reads a word its
// own stack wrote.
module two_stacks_shared_memory (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         cmd,
    input  logic signed [31:0] push_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] pop_data,
    output logic [1:0]         status
);
    import tssm_pkg::*;

    dp_cmd_t   dp_cmd;
    dp_flags_t flags;

    // sequencer: takes one word, holds its result until taken
    tssm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .flags     (flags),
        .dp_cmd    (dp_cmd)
    );

    // counts, shared memory and result registers
    tssm_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .dp_cmd     (dp_cmd),
        .push_value (push_value),
        .flags      (flags),
        .pop_data   (pop_data),
        .status     (status)
    );

    // an accepted word always yields a result on the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> out_valid)
        else $error("no result after accepted word");

    // no new word taken while a result is pending
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("word accepted while result pending");

    // underflow carries all-ones data
    a_underflow_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_UNDERFLOW) |-> (pop_data == -32'sd1))
        else $error("underflow data not all ones");

    // overflow refusals carry zero data
    a_overflow_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_OVERFLOW) |-> (pop_data == 32'sd0))
        else $error("overflow data not zero");

endmodule
